// ===== rtl/core/prru_pkg.sv =====
// ----------------------------------------------------------------------------
// prru_pkg: shared types and constants for the permutation rank/unrank unit
// Holds the item payload structs, the working record that travels down the
// per-position pipeline, and the factorial helper used at elaboration.
// ----------------------------------------------------------------------------
package prru_pkg;

	// Positions carried by one item, element width and rank width.
	localparam int SLOTS  = 8;
	localparam int ELEM_W = 3;
	localparam int RANK_W = 16;

	// Function codes.
	localparam logic FUNC_RANK   = 1'b0;
	localparam logic FUNC_UNRANK = 1'b1;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef elem_t [SLOTS-1:0] elem_vec_t;

	// Input item.
	typedef struct packed {
		logic              func;
		elem_t             perm_0;
		elem_t             perm_1;
		elem_t             perm_2;
		elem_t             perm_3;
		elem_t             perm_4;
		elem_t             perm_5;
		elem_t             perm_6;
		elem_t             perm_7;
		logic [RANK_W-1:0] rank_in;
	} prru_in_t;

	// Result item.
	typedef struct packed {
		logic [RANK_W-1:0] rank_out;
		elem_t             elem_0;
		elem_t             elem_1;
		elem_t             elem_2;
		elem_t             elem_3;
		elem_t             elem_4;
		elem_t             elem_5;
		elem_t             elem_6;
		elem_t             elem_7;
		logic              bad_rank;
	} prru_out_t;

	// Working record of one item inside the pipeline. In rank mode acc is the
	// running rank; in unrank mode it is the remainder still to be decoded.
	typedef struct packed {
		logic              func;
		logic              bad;
		elem_vec_t         perm;
		logic [RANK_W-1:0] acc;
		elem_vec_t         free_list;
		elem_vec_t         elem;
	} prru_work_t;

	// Factorial, evaluated on constants only.
	function automatic int fact(input int k);
		int f;
		f = 1;
		for (int i = 2; i <= k; i++) begin
			f = f * i;
		end
		return f;
	endfunction

endpackage

// ===== rtl/core/prru_stage.sv =====
// ----------------------------------------------------------------------------
// prru_stage: one position of the rank/unrank pipeline
// Rank mode adds this position's Lehmer digit times its factorial weight.
// Unrank mode extracts the digit by constant compares, emits the chosen free
// element and closes the gap in the free list. One register at the output.
// ----------------------------------------------------------------------------
module prru_stage #(
	parameter int NUM_ACT = 8,
	parameter int POS     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  prru_pkg::prru_work_t in_work,
	input  logic                 nxt_adv,
	output logic                 adv,
	output logic                 valid_s,
	output prru_pkg::prru_work_t work_s
);

	localparam int DIG   = NUM_ACT - 1 - POS;
	localparam int FACT  = prru_pkg::fact(DIG);
	localparam int CMP_W = prru_pkg::RANK_W + 1;

	prru_pkg::prru_work_t nx;

	// Digit logic for this position.
	always_comb begin
		logic [prru_pkg::ELEM_W-1:0] cnt;
		logic [prru_pkg::ELEM_W-1:0] q;
		cnt = '0;
		q   = '0;
		nx  = in_work;
		// Later active elements that are smaller than this one.
		for (int j = 0; j < prru_pkg::SLOTS; j++) begin
			if (j > POS && j < NUM_ACT && in_work.perm[j] < in_work.perm[POS]) begin
				cnt = cnt + 1'b1;
			end
		end
		// Quotient by the factorial weight: count the multiples not above acc.
		for (int m = 1; m < prru_pkg::SLOTS; m++) begin
			if (m <= DIG && {1'b0, in_work.acc} >= CMP_W'(m * FACT)) begin
				q = q + 1'b1;
			end
		end
		if (in_work.func == prru_pkg::FUNC_RANK) begin
			nx.acc = in_work.acc + prru_pkg::RANK_W'(int'(cnt) * FACT);
		end else begin
			nx.acc       = in_work.acc - prru_pkg::RANK_W'(int'(q) * FACT);
			nx.elem[POS] = in_work.free_list[q];
			for (int j = 0; j < prru_pkg::SLOTS - 1; j++) begin
				if (j >= int'(q)) begin
					nx.free_list[j] = in_work.free_list[j+1];
				end
			end
		end
	end

	// The stage moves when it is empty or its successor takes its item.
	assign adv = !valid_s || nxt_adv;

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (adv) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			work_s <= nx;
		end
	end

endmodule

// ===== rtl/core/permutation_rank_unrank_unit.sv =====
// ----------------------------------------------------------------------------
// permutation_rank_unrank_unit: permutation to lexicographic rank and back
// Ranks a permutation of NUM_ELEMS elements or rebuilds one from its rank.
// ----------------------------------------------------------------------------
// The unit accepts one item every clock cycle while cmd_stall is low. Each item
// passes through one input register followed by one register stage per
// position, each of which handles one factorial-base digit
// (rank: add digit times weight; unrank: divide by the constant weight through
// compares, pick and remove a free element). Each stage holds its item only
// while the next one is full and stalled, so bubbles close up while the
// result waits. An unrank input at or above the factorial of the active length
// returns bad_rank with all elements zero; rank mode returns zero elements and
// unrank mode a zero rank.
module permutation_rank_unrank_unit #(
	parameter int NUM_ELEMS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  prru_pkg::prru_in_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output prru_pkg::prru_out_t res
);

	localparam int NUM_ACT = (NUM_ELEMS < prru_pkg::SLOTS) ? NUM_ELEMS : prru_pkg::SLOTS;
	localparam int FACT_N  = prru_pkg::fact(NUM_ACT);
	localparam int CMP_W   = prru_pkg::RANK_W + 1;

	logic                 stg_valid [NUM_ACT+1];
	prru_pkg::prru_work_t stg_work  [NUM_ACT+1];
	logic                 stg_adv   [NUM_ACT+2];

	logic                 valid_s0;
	prru_pkg::prru_work_t work_s0;
	prru_pkg::prru_work_t init_work;
	prru_pkg::prru_work_t last_work;

	// Initial working record: range check, identity free list, cleared result.
	always_comb begin
		init_work        = '0;
		init_work.func   = cmd.func;
		init_work.bad    = (cmd.func == prru_pkg::FUNC_UNRANK) &&
			({1'b0, cmd.rank_in} >= CMP_W'(FACT_N));
		init_work.perm[0] = cmd.perm_0;
		init_work.perm[1] = cmd.perm_1;
		init_work.perm[2] = cmd.perm_2;
		init_work.perm[3] = cmd.perm_3;
		init_work.perm[4] = cmd.perm_4;
		init_work.perm[5] = cmd.perm_5;
		init_work.perm[6] = cmd.perm_6;
		init_work.perm[7] = cmd.perm_7;
		init_work.acc    = (cmd.func == prru_pkg::FUNC_UNRANK) ? cmd.rank_in : '0;
		for (int j = 0; j < prru_pkg::SLOTS; j++) begin
			init_work.free_list[j] = prru_pkg::ELEM_W'(j);
		end
	end

	// Input register and its place in the stall chain.
	assign stg_adv[0]          = !valid_s0 || stg_adv[1];
	assign stg_adv[NUM_ACT+1]  = !res_stall;
	assign cmd_stall           = !stg_adv[0];
	assign stg_valid[0]        = valid_s0;
	assign stg_work[0]         = work_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (stg_adv[0]) begin
			valid_s0 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stg_adv[0] && cmd_valid) begin
			work_s0 <= init_work;
		end
	end

	// One stage per active position.
	for (genvar k = 0; k < NUM_ACT; k++) begin : g_pos
		prru_stage #(
			.NUM_ACT (NUM_ACT),
			.POS     (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_valid[k]),
			.in_work  (stg_work[k]),
			.nxt_adv  (stg_adv[k+2]),
			.adv      (stg_adv[k+1]),
			.valid_s  (stg_valid[k+1]),
			.work_s   (stg_work[k+1])
		);
	end

	// Result formatting from the last stage.
	assign last_work = stg_work[NUM_ACT];
	assign res_valid = stg_valid[NUM_ACT];

	always_comb begin
		logic show;
		show         = (last_work.func == prru_pkg::FUNC_UNRANK) && !last_work.bad;
		res          = '0;
		res.rank_out = (last_work.func == prru_pkg::FUNC_RANK) ? last_work.acc : '0;
		res.bad_rank = (last_work.func == prru_pkg::FUNC_UNRANK) && last_work.bad;
		if (show) begin
			res.elem_0 = last_work.elem[0];
			res.elem_1 = last_work.elem[1];
			res.elem_2 = last_work.elem[2];
			res.elem_3 = last_work.elem[3];
			res.elem_4 = last_work.elem[4];
			res.elem_5 = last_work.elem[5];
			res.elem_6 = last_work.elem[6];
			res.elem_7 = last_work.elem[7];
		end
	end

`ifndef NO_ASSERTIONS
	// The input side only stalls when every stage is full and the result waits.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall && valid_s0)
		else $error("input stalled while the pipeline has room");

	// A delivered rank always lies below the factorial of the active length.
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res.rank_out} < CMP_W'(FACT_N)))
		else $error("rank out of range");

	// An out-of-range unrank gives a zero rank and no elements.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.bad_rank |-> res.rank_out == '0 && res.elem_0 == '0 &&
			res.elem_1 == '0 && res.elem_7 == '0)
		else $error("bad rank result carries data");

	// An item accepted with a free pipeline shows up in the input register.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> valid_s0)
		else $error("accepted item lost at the input register");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: permutation rank/unrank unit
// Sends rank and unrank items through the unit with random gaps on the
// command side and random stalls on the result side. A behavioral Lehmer
// code predictor works out each result, and every result is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_POS      = 8;
	localparam int ACTIVE       = (NUM_POS < prru_pkg::SLOTS) ? NUM_POS : prru_pkg::SLOTS;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1230;

	// A queued item, optionally held back until the unit has drained.
	typedef struct {
		bit                 drain_first;
		prru_pkg::prru_in_t cmd;
	} pending_item_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	prru_pkg::prru_in_t  cmd       = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	prru_pkg::prru_out_t res;

	pending_item_t       pending_items[$];
	prru_pkg::prru_out_t expected_results[$];
	int                  error_count  = 0;
	int                  result_count = 0;
	int                  idle_cycles  = 0;
	int                  gap_left     = 0;
	int                  stall_left   = 0;
	int                  send_calm    = 0;
	int                  recv_calm    = 0;

	permutation_rank_unrank_unit #(
		.NUM_ELEMS(NUM_POS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// Free-running clock.
	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned factorial_of(input int k);
		int unsigned f;
		f = 1;
		for (int i = 2; i <= k; i++) begin
			f = f * i;
		end
		return f;
	endfunction

	function automatic prru_pkg::elem_vec_t item_perms(input prru_pkg::prru_in_t c);
		prru_pkg::elem_vec_t v;
		v[0] = c.perm_0;
		v[1] = c.perm_1;
		v[2] = c.perm_2;
		v[3] = c.perm_3;
		v[4] = c.perm_4;
		v[5] = c.perm_5;
		v[6] = c.perm_6;
		v[7] = c.perm_7;
		return v;
	endfunction

	function automatic prru_pkg::elem_vec_t result_elems(input prru_pkg::prru_out_t r);
		prru_pkg::elem_vec_t v;
		v[0] = r.elem_0;
		v[1] = r.elem_1;
		v[2] = r.elem_2;
		v[3] = r.elem_3;
		v[4] = r.elem_4;
		v[5] = r.elem_5;
		v[6] = r.elem_6;
		v[7] = r.elem_7;
		return v;
	endfunction

	// Lehmer code predictor: ranks a permutation or rebuilds one from a rank.
	function automatic prru_pkg::prru_out_t predict_lehmer(input prru_pkg::prru_in_t c);
		prru_pkg::prru_out_t r;
		prru_pkg::elem_vec_t vals;
		prru_pkg::elem_vec_t pool;
		prru_pkg::elem_vec_t picked;
		int unsigned         rank_sum;
		int unsigned         remaining;
		int unsigned         weight;
		int unsigned         pick;
		int                  smaller;
		int                  pool_len;
		r      = '0;
		picked = '0;
		if (c.func == prru_pkg::FUNC_RANK) begin
			// Each position adds its count of later smaller values times its weight.
			vals     = item_perms(c);
			rank_sum = 0;
			for (int i = 0; i < ACTIVE; i++) begin
				smaller = 0;
				for (int j = i + 1; j < ACTIVE; j++) begin
					if (vals[i] > vals[j]) begin
						smaller++;
					end
				end
				rank_sum += smaller * factorial_of(ACTIVE - 1 - i);
			end
			r.rank_out = rank_sum[prru_pkg::RANK_W-1:0];
		end else if (c.rank_in >= factorial_of(ACTIVE)) begin
			r.bad_rank = 1'b1;
		end else begin
			// Peel off one factorial-base digit per position and take that free entry.
			remaining = c.rank_in;
			pool_len  = ACTIVE;
			for (int i = 0; i < prru_pkg::SLOTS; i++) begin
				pool[i] = prru_pkg::elem_t'(i);
			end
			for (int i = 0; i < ACTIVE; i++) begin
				weight    = factorial_of(ACTIVE - 1 - i);
				pick      = remaining / weight;
				remaining = remaining % weight;
				if (pick >= pool_len) begin
					pick = pool_len - 1;
				end
				picked[i] = pool[pick];
				for (int j = pick; j + 1 < pool_len; j++) begin
					pool[j] = pool[j + 1];
				end
				pool_len--;
			end
		end
		r.elem_0 = picked[0];
		r.elem_1 = picked[1];
		r.elem_2 = picked[2];
		r.elem_3 = picked[3];
		r.elem_4 = picked[4];
		r.elem_5 = picked[5];
		r.elem_6 = picked[6];
		r.elem_7 = picked[7];
		return r;
	endfunction

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end
		if (r < 95) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(15, 50);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR result %0d, %s: got %0d, wanted %0d", result_count, what, got, want);
		error_count++;
	endtask

	task automatic check_result(input prru_pkg::prru_out_t got,
			input prru_pkg::prru_out_t want);
		prru_pkg::elem_vec_t g;
		prru_pkg::elem_vec_t w;
		g = result_elems(got);
		w = result_elems(want);
		if (got.rank_out !== want.rank_out) begin
			report_mismatch("rank_out", got.rank_out, want.rank_out);
		end
		if (got.bad_rank !== want.bad_rank) begin
			report_mismatch("bad_rank", got.bad_rank, want.bad_rank);
		end
		for (int i = 0; i < prru_pkg::SLOTS; i++) begin
			if (g[i] !== w[i]) begin
				report_mismatch($sformatf("elem_%0d", i), g[i], w[i]);
			end
		end
	endtask

	task automatic queue_item(input bit drain, input logic func,
			input prru_pkg::elem_vec_t v, input logic [prru_pkg::RANK_W-1:0] rk);
		pending_item_t p;
		p.drain_first  = drain;
		p.cmd.func     = func;
		p.cmd.perm_0   = v[0];
		p.cmd.perm_1   = v[1];
		p.cmd.perm_2   = v[2];
		p.cmd.perm_3   = v[3];
		p.cmd.perm_4   = v[4];
		p.cmd.perm_5   = v[5];
		p.cmd.perm_6   = v[6];
		p.cmd.perm_7   = v[7];
		p.cmd.rank_in  = rk;
		pending_items.push_back(p);
	endtask

	// Command driver: predicts each item as it is accepted, then presents the next.
	always @(posedge clk or negedge arst_n) begin
		logic               busy;
		logic               next_valid;
		prru_pkg::prru_in_t next_cmd;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			busy = cmd_valid;
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(predict_lehmer(cmd));
				busy = 1'b0;
			end
			next_valid = busy;
			next_cmd   = cmd;
			if (!busy) begin
				if (send_calm > 0) begin
					send_calm--;
				end else if ($urandom_range(0, 399) == 0) begin
					send_calm = $urandom_range(50, 200);
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0 &&
						!(pending_items[0].drain_first && expected_results.size() > 0)) begin
					next_cmd = pending_items[0].cmd;
					void'(pending_items.pop_front());
					next_valid = 1'b1;
					gap_left   = (send_calm > 0 || $urandom_range(0, 99) >= 30) ?
						0 : idle_length();
				end
			end
			cmd_valid <= next_valid;
			cmd       <= next_cmd;
		end
	end

	// Result monitor: checks each accepted result and throttles with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("no prediction pending", res.rank_out, 0);
				end else begin
					check_result(res, expected_results.pop_front());
				end
				result_count++;
			end
			if (recv_calm > 0) begin
				recv_calm--;
			end else if ($urandom_range(0, 399) == 0) begin
				recv_calm = $urandom_range(50, 200);
			end
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (recv_calm == 0 && $urandom_range(0, 99) < 25) begin
				stall_left = idle_length() - 1;
				res_stall  <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		prru_pkg::elem_vec_t v;
		prru_pkg::elem_t     swap_e;
		int unsigned         top_rank;
		int                  kind;
		int                  k;
		bit                  drain;
		top_rank = factorial_of(ACTIVE);

		// Directed rank items: identity, reversed, constant fills, neighbors, repeats.
		for (int i = 0; i < prru_pkg::SLOTS; i++) begin
			v[i] = prru_pkg::elem_t'(i);
		end
		queue_item(1'b0, prru_pkg::FUNC_RANK, v,
			prru_pkg::RANK_W'($urandom_range(0, 65535)));
		for (int i = 0; i < prru_pkg::SLOTS; i++) begin
			v[i] = prru_pkg::elem_t'(prru_pkg::SLOTS - 1 - i);
		end
		queue_item(1'b0, prru_pkg::FUNC_RANK, v, '0);
		queue_item(1'b0, prru_pkg::FUNC_RANK, '0, '1);
		queue_item(1'b0, prru_pkg::FUNC_RANK, '1, '0);
		for (int i = 0; i < prru_pkg::SLOTS; i++) begin
			v[i] = prru_pkg::elem_t'(i);
		end
		v[0] = 3'd1;
		v[1] = 3'd0;
		queue_item(1'b0, prru_pkg::FUNC_RANK, v, '0);
		for (int i = 0; i < prru_pkg::SLOTS; i++) begin
			v[i] = prru_pkg::elem_t'(i);
		end
		v[ACTIVE - 2] = prru_pkg::elem_t'(ACTIVE - 1);
		v[ACTIVE - 1] = prru_pkg::elem_t'(ACTIVE - 2);
		queue_item(1'b0, prru_pkg::FUNC_RANK, v, '1);
		v = {3'd7, 3'd0, 3'd2, 3'd7, 3'd0, 3'd5, 3'd2, 3'd5};
		queue_item(1'b0, prru_pkg::FUNC_RANK, v, '0);
		v = {3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd3, 3'd6};
		queue_item(1'b0, prru_pkg::FUNC_RANK, v, '0);

		// Directed unrank items: both ends of the legal range and beyond it.
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '1, '0);
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0, prru_pkg::RANK_W'(top_rank - 1));
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0, prru_pkg::RANK_W'(top_rank));
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '1, '1);
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0, 16'd1);
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0,
			prru_pkg::RANK_W'(factorial_of(ACTIVE - 1)));
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0,
			prru_pkg::RANK_W'(factorial_of(ACTIVE - 1) - 1));
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0, 16'h5555);
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0, 16'hAAAA);
		queue_item(1'b0, prru_pkg::FUNC_UNRANK, '0, 16'd12345);

		// Random mix, weighted toward true permutations and in-range ranks.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind  = $urandom_range(0, 99);
			drain = (n == 0) || ($urandom_range(0, 99) == 0);
			for (int i = 0; i < prru_pkg::SLOTS; i++) begin
				v[i] = prru_pkg::elem_t'($urandom_range(0, 7));
			end
			if (kind < 40) begin
				for (int i = 0; i < ACTIVE; i++) begin
					v[i] = prru_pkg::elem_t'(i);
				end
				for (int i = ACTIVE - 1; i > 0; i--) begin
					k      = $urandom_range(0, i);
					swap_e = v[i];
					v[i]   = v[k];
					v[k]   = swap_e;
				end
				queue_item(drain, prru_pkg::FUNC_RANK, v,
					prru_pkg::RANK_W'($urandom_range(0, 65535)));
			end else if (kind < 55) begin
				queue_item(drain, prru_pkg::FUNC_RANK, v,
					prru_pkg::RANK_W'($urandom_range(0, 65535)));
			end else if (kind < 90) begin
				queue_item(drain, prru_pkg::FUNC_UNRANK, v,
					prru_pkg::RANK_W'($urandom_range(0, top_rank - 1)));
			end else begin
				queue_item(drain, prru_pkg::FUNC_UNRANK, v,
					prru_pkg::RANK_W'($urandom_range(0, 65535)));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every item to go in and every result to come back.
		while (pending_items.size() > 0 || cmd_valid || expected_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (ACTIVE + 10) @(posedge clk);
		if (expected_results.size() > 0) begin
			report_mismatch("results never arrived", expected_results.size(), 0);
		end
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
